// File: rtl/core/cdsd_pkg.sv
// Shared types, constants and calendar tables of the civil date converter.
`default_nettype none

package cdsd_pkg;

    // Operation codes carried by each request.
    typedef enum logic [1:0] {
        OP_TO_DAYS      = 2'd0,
        OP_TO_DATE      = 2'd1,
        OP_ADD_DAYS     = 2'd2,
        OP_DAYS_BETWEEN = 2'd3
    } op_t;

    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int COUNT_W  = 23;
    localparam int SERIAL_W = 24;
    localparam int LANES    = 2;

    // Calendar constants of the March-based year.
    localparam int EPOCH_SHIFT = 719468;
    localparam int ERA_DAYS    = 146097;
    localparam int CENT_DAYS   = 36524;
    localparam int QUAD_DAYS   = 1460;
    localparam int YEAR_DAYS   = 365;
    localparam int ERA_YEARS   = 400;
    localparam int MIN_SERIAL  = -719162;
    localparam int MAX_SERIAL  = 2932896;
    localparam int NUM_LIMIT   = 3652058;

    typedef logic [YEAR_W-1:0]          year_t;
    typedef logic [MONTH_W-1:0]         month_t;
    typedef logic [DAY_W-1:0]           mday_t;
    typedef logic signed [COUNT_W-1:0]  count_t;
    typedef logic signed [SERIAL_W-1:0] serial_t;

    // Sideband that travels with a request through the date-to-serial stages.
    typedef struct packed {
        op_t    op;
        count_t cnt;
    } req_side_t;

    // Sideband that travels with a request through the serial-to-date stages.
    typedef struct packed {
        op_t    op;
        count_t num;
        logic   flag;
    } res_side_t;

    // Days from 1 March to the first day of the given month of the shifted year.
    function automatic logic [8:0] cum_days(input logic [3:0] mm);
        logic [8:0] res;
        case (mm)
            4'd0:    res = 9'd0;
            4'd1:    res = 9'd31;
            4'd2:    res = 9'd61;
            4'd3:    res = 9'd92;
            4'd4:    res = 9'd122;
            4'd5:    res = 9'd153;
            4'd6:    res = 9'd184;
            4'd7:    res = 9'd214;
            4'd8:    res = 9'd245;
            4'd9:    res = 9'd275;
            4'd10:   res = 9'd306;
            4'd11:   res = 9'd337;
            4'd12:   res = 9'd367;
            default: res = 9'd0;
        endcase
        return res;
    endfunction

    // Whole centuries within a year of era (0 to 399).
    function automatic logic [1:0] cent_of(input logic [8:0] yoe);
        logic [1:0] res;
        if (yoe >= 9'd300) begin
            res = 2'd3;
        end else if (yoe >= 9'd200) begin
            res = 2'd2;
        end else if (yoe >= 9'd100) begin
            res = 2'd1;
        end else begin
            res = 2'd0;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/civil_date_serial_day_converter_top.sv
// Top level of the civil date and serial day converter.
`default_nettype none

// Converts proleptic Gregorian dates (years 1 to 9999) to and from a day number
// counted from 1970-01-01, adds a signed day offset to a date, or counts the
// days between two dates, as chosen by op. The block takes one request in every
// cycle when the result side does not stall: four stages turn both dates into
// day numbers, one stage picks the operation and clamps, and seven stages turn
// the day number back into a date. Each division by a calendar constant is a
// multiplication by its reciprocal or a comparison with its multiples, with a
// register after it, which sets the number of stages. A stall of the result
// side holds the result, and requests are still taken until the pipeline is
// full. A resulting date outside years 1 to 9999 is clamped to the nearer
// limit and out_of_range is set; day counts saturate at +/-3652058.
module civil_date_serial_day_converter_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  logic [1:0]          op,
    input  cdsd_pkg::year_t     year,
    input  cdsd_pkg::month_t    month,
    input  cdsd_pkg::mday_t     day,
    input  cdsd_pkg::year_t     year_b,
    input  cdsd_pkg::month_t    month_b,
    input  cdsd_pkg::mday_t     day_b,
    input  cdsd_pkg::count_t    day_count,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output cdsd_pkg::count_t    day_number,
    output cdsd_pkg::year_t     out_year,
    output cdsd_pkg::month_t    out_month,
    output cdsd_pkg::mday_t     out_day,
    output logic                out_of_range
);
    import cdsd_pkg::*;

    localparam int SUM_W = SERIAL_W + 1;

    year_t     yr_lane  [LANES];
    month_t    mon_lane [LANES];
    mday_t     dom_lane [LANES];
    req_side_t req_side;
    logic      ser_ready;

    // Lane zero carries the first date, lane one the second.
    assign yr_lane[0]  = year;
    assign yr_lane[1]  = year_b;
    assign mon_lane[0] = month;
    assign mon_lane[1] = month_b;
    assign dom_lane[0] = day;
    assign dom_lane[1] = day_b;
    assign req_side    = '{op: op_t'(op), cnt: day_count};
    assign req_stall   = !ser_ready;

    logic      ser_valid;
    logic      sel_adv;
    serial_t   ser      [LANES];
    req_side_t ser_side;

    cdsd_serial u_serial (
        .clk        (clk),
        .rst_n      (rst_n),
        .src_valid  (req_valid),
        .src_ready  (ser_ready),
        .year_lane  (yr_lane),
        .month_lane (mon_lane),
        .day_lane   (dom_lane),
        .side_in    (req_side),
        .dst_valid  (ser_valid),
        .dst_ready  (sel_adv),
        .serial     (ser),
        .side_out   (ser_side)
    );

    // Saturate a day count to the span of the day number field.
    function automatic count_t sat_num(input logic signed [SUM_W-1:0] v);
        count_t res;
        if (v > SUM_W'(NUM_LIMIT))
        begin
            res = COUNT_W'(NUM_LIMIT);
        end
        else if (v < SUM_W'(-NUM_LIMIT))
        begin
            res = COUNT_W'(-NUM_LIMIT);
        end
        else
        begin
            res = COUNT_W'(v);
        end
        return res;
    endfunction

    logic signed [SUM_W-1:0] s_a;
    logic signed [SUM_W-1:0] s_diff;
    logic signed [SUM_W-1:0] s_sum;
    logic signed [SUM_W-1:0] s_pick;
    count_t                  num_next;
    count_t                  date_next;
    logic                    flag_next;

    logic      sel_vld_reg;
    count_t    sel_date_reg;
    res_side_t sel_side_reg;
    logic      civ_ready;

    // Select the operation, saturate the day count and clamp the date to years 1 to 9999.
    always_comb
    begin
        s_a    = SUM_W'(ser[0]);
        s_diff = SUM_W'(ser[1]) - s_a;
        s_sum  = s_a + SUM_W'(ser_side.cnt);
        case (ser_side.op)
            OP_TO_DAYS:
            begin
                num_next = sat_num(s_a);
                s_pick   = SUM_W'(ser_side.cnt);
            end
            OP_DAYS_BETWEEN:
            begin
                num_next = sat_num(s_diff);
                s_pick   = SUM_W'(ser_side.cnt);
            end
            OP_ADD_DAYS:
            begin
                num_next = '0;
                s_pick   = s_sum;
            end
            default:
            begin
                num_next = '0;
                s_pick   = SUM_W'(ser_side.cnt);
            end
        endcase
        if (s_pick < SUM_W'(MIN_SERIAL))
        begin
            date_next = COUNT_W'(MIN_SERIAL);
            flag_next = 1'b1;
        end
        else if (s_pick > SUM_W'(MAX_SERIAL))
        begin
            date_next = COUNT_W'(MAX_SERIAL);
            flag_next = 1'b1;
        end
        else
        begin
            date_next = COUNT_W'(s_pick);
            flag_next = 1'b0;
        end
    end

    assign sel_adv = !sel_vld_reg || civ_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_vld_reg <= 1'b0;
        end
        else if (sel_adv)
        begin
            sel_vld_reg <= ser_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sel_adv)
        begin
            sel_date_reg <= date_next;
            sel_side_reg <= '{op: ser_side.op, num: num_next, flag: flag_next};
        end
    end

    cdsd_civil u_civil (
        .clk          (clk),
        .rst_n        (rst_n),
        .src_valid    (sel_vld_reg),
        .src_ready    (civ_ready),
        .serial       (sel_date_reg),
        .side         (sel_side_reg),
        .dst_valid    (rsp_valid),
        .dst_ready    (!rsp_stall),
        .day_number   (day_number),
        .out_year     (out_year),
        .out_month    (out_month),
        .out_day      (out_day),
        .out_of_range (out_of_range)
    );

endmodule

`default_nettype wire

// File: rtl/core/cdsd_serial.sv
// Four-stage pipeline that turns two calendar dates into serial day numbers.
`default_nettype none

module cdsd_serial (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                src_valid,
    output logic                src_ready,
    input  cdsd_pkg::year_t     year_lane  [cdsd_pkg::LANES],
    input  cdsd_pkg::month_t    month_lane [cdsd_pkg::LANES],
    input  cdsd_pkg::mday_t     day_lane   [cdsd_pkg::LANES],
    input  cdsd_pkg::req_side_t side_in,
    output logic                dst_valid,
    input  logic                dst_ready,
    output cdsd_pkg::serial_t   serial     [cdsd_pkg::LANES],
    output cdsd_pkg::req_side_t side_out
);
    import cdsd_pkg::*;

    localparam int NST      = 4;
    localparam int T_W      = 15;
    localparam int QPROD_W  = 31;
    localparam int Q400_MUL = 41944;
    localparam int Q400_SH  = 24;

    logic [NST-1:0] vld_reg;
    logic [NST-1:0] adv;

    // Each stage moves on when it is empty or the stage after it moves on.
    always_comb
    begin
        adv[NST-1] = !vld_reg[NST-1] || dst_ready;
        for (int k = NST - 2; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    assign src_ready = adv[0];
    assign dst_valid = vld_reg[NST-1];

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= src_valid;
            end
            for (int k = 1; k < NST; k++)
            begin
                if (adv[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    logic               m_le2      [LANES];
    logic [3:0]         mm         [LANES];
    logic [T_W-1:0]     t_next     [LANES];
    logic [QPROD_W-1:0] qprod      [LANES];
    logic [5:0]         q_next     [LANES];
    logic signed [9:0]  doy_next   [LANES];

    logic [T_W-1:0]     s1_t_reg   [LANES];
    logic [5:0]         s1_q_reg   [LANES];
    logic signed [9:0]  s1_doy_reg [LANES];
    req_side_t          s1_side_reg;

    // Stage one: shift the year to start in March, divide by 400 and find the day of the year.
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            m_le2[l]    = month_lane[l] <= 4'd2;
            t_next[l]   = T_W'(year_lane[l]) + T_W'(ERA_YEARS) - T_W'(m_le2[l]);
            qprod[l]    = QPROD_W'(t_next[l]) * QPROD_W'(Q400_MUL);
            q_next[l]   = qprod[l][Q400_SH+5:Q400_SH];
            mm[l]       = m_le2[l] ? month_lane[l] + 4'd9 : month_lane[l] - 4'd3;
            doy_next[l] = $signed({1'b0, cum_days(mm[l])})
                        + $signed({5'b0, day_lane[l]}) - 10'sd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            for (int l = 0; l < LANES; l++)
            begin
                s1_t_reg[l]   <= t_next[l];
                s1_q_reg[l]   <= q_next[l];
                s1_doy_reg[l] <= doy_next[l];
            end
            s1_side_reg <= side_in;
        end
    end

    logic signed [6:0]  era_next   [LANES];
    logic [8:0]         yoe_next   [LANES];

    logic signed [6:0]  s2_era_reg [LANES];
    logic [8:0]         s2_yoe_reg [LANES];
    logic signed [9:0]  s2_doy_reg [LANES];
    req_side_t          s2_side_reg;

    // Stage two: era and year of era from quotient and remainder.
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            era_next[l] = $signed({1'b0, s1_q_reg[l]}) - 7'sd1;
            yoe_next[l] = 9'(s1_t_reg[l] - T_W'(s1_q_reg[l]) * T_W'(ERA_YEARS));
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            for (int l = 0; l < LANES; l++)
            begin
                s2_era_reg[l] <= era_next[l];
                s2_yoe_reg[l] <= yoe_next[l];
                s2_doy_reg[l] <= s1_doy_reg[l];
            end
            s2_side_reg <= s1_side_reg;
        end
    end

    logic [17:0]        doe_base   [LANES];
    logic signed [18:0] doe_next   [LANES];
    serial_t            eday_next  [LANES];

    logic signed [18:0] s3_doe_reg  [LANES];
    serial_t            s3_eday_reg [LANES];
    req_side_t          s3_side_reg;

    // Stage three: day of era and the days of all whole eras.
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            doe_base[l]  = 18'(s2_yoe_reg[l]) * 18'(YEAR_DAYS)
                         + 18'(s2_yoe_reg[l][8:2]) - 18'(cent_of(s2_yoe_reg[l]));
            doe_next[l]  = $signed({1'b0, doe_base[l]}) + 19'(s2_doy_reg[l]);
            eday_next[l] = SERIAL_W'(s2_era_reg[l]) * SERIAL_W'(ERA_DAYS);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            for (int l = 0; l < LANES; l++)
            begin
                s3_doe_reg[l]  <= doe_next[l];
                s3_eday_reg[l] <= eday_next[l];
            end
            s3_side_reg <= s2_side_reg;
        end
    end

    serial_t   ser_next   [LANES];
    serial_t   s4_ser_reg [LANES];
    req_side_t s4_side_reg;

    // Stage four: add the era days to the day of era and move the origin to 1970-01-01.
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            ser_next[l] = s3_eday_reg[l] + SERIAL_W'(s3_doe_reg[l])
                        - SERIAL_W'(EPOCH_SHIFT);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            for (int l = 0; l < LANES; l++)
            begin
                s4_ser_reg[l] <= ser_next[l];
            end
            s4_side_reg <= s3_side_reg;
        end
    end

    assign serial   = s4_ser_reg;
    assign side_out = s4_side_reg;

endmodule

`default_nettype wire

// File: rtl/core/cdsd_civil.sv
// Seven-stage pipeline that turns a clamped serial day into a date and forms the result.
`default_nettype none

module cdsd_civil (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                src_valid,
    output logic                src_ready,
    input  cdsd_pkg::count_t    serial,
    input  cdsd_pkg::res_side_t side,
    output logic                dst_valid,
    input  logic                dst_ready,
    output cdsd_pkg::count_t    day_number,
    output cdsd_pkg::year_t     out_year,
    output cdsd_pkg::month_t    out_month,
    output cdsd_pkg::mday_t     out_day,
    output logic                out_of_range
);
    import cdsd_pkg::*;

    localparam int NST       = 7;
    localparam int Z_W       = 22;
    localparam int DOE_W     = 18;
    localparam int ERA_MUL   = 29398;
    localparam int ERA_SH    = 32;
    localparam int ERA_PW    = Z_W + 15;
    localparam int DIV_MUL   = 183860;
    localparam int QUAD_SH   = 28;
    localparam int YEAR_SH   = 26;
    localparam int DIV_PW    = 2 * DOE_W;
    localparam int MP_MUL    = 1714;
    localparam int MP_SH     = 18;
    localparam int MP_PW     = 22;

    logic [NST-1:0] vld_reg;
    logic [NST-1:0] adv;

    // Each stage moves on when it is empty or the stage after it moves on.
    always_comb
    begin
        adv[NST-1] = !vld_reg[NST-1] || dst_ready;
        for (int k = NST - 2; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    assign src_ready = adv[0];
    assign dst_valid = vld_reg[NST-1];

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= src_valid;
            end
            for (int k = 1; k < NST; k++)
            begin
                if (adv[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    serial_t           z_wide;
    logic [Z_W-1:0]    z_next;
    logic [ERA_PW-1:0] eprod;
    logic [Z_W-1:0]    c1_z_reg;
    logic [4:0]        c1_q_reg;
    res_side_t         c1_side_reg;

    // Stage one: day count from 0000-03-01 and an estimate of the era.
    always_comb
    begin
        z_wide = SERIAL_W'(serial) + SERIAL_W'(EPOCH_SHIFT);
        z_next = z_wide[Z_W-1:0];
        eprod  = ERA_PW'(z_next) * ERA_PW'(ERA_MUL);
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            c1_z_reg    <= z_next;
            c1_q_reg    <= eprod[ERA_SH+4:ERA_SH];
            c1_side_reg <= side;
        end
    end

    logic [22:0]      rem;
    logic [4:0]       era_next;
    logic [DOE_W-1:0] doe_next;
    logic [4:0]       c2_era_reg;
    logic [DOE_W-1:0] c2_doe_reg;
    res_side_t        c2_side_reg;

    // Stage two: the estimate is at most one low, so one correction settles it.
    always_comb
    begin
        rem = 23'(c1_z_reg) - 23'(c1_q_reg) * 23'(ERA_DAYS);
        if (rem >= 23'(ERA_DAYS))
        begin
            era_next = c1_q_reg + 5'd1;
            doe_next = DOE_W'(rem - 23'(ERA_DAYS));
        end
        else
        begin
            era_next = c1_q_reg;
            doe_next = DOE_W'(rem);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            c2_era_reg  <= era_next;
            c2_doe_reg  <= doe_next;
            c2_side_reg <= c1_side_reg;
        end
    end

    logic [DIV_PW-1:0] qprod;
    logic [2:0]        cent_next;
    logic [4:0]        c3_era_reg;
    logic [DOE_W-1:0]  c3_doe_reg;
    logic [6:0]        c3_quad_reg;
    logic [2:0]        c3_cent_reg;
    logic              c3_last_reg;
    res_side_t         c3_side_reg;

    // Stage three: leap corrections within the era.
    always_comb
    begin
        qprod = DIV_PW'(c2_doe_reg) * DIV_PW'(DIV_MUL);
        if (c2_doe_reg >= DOE_W'(4 * CENT_DAYS))
        begin
            cent_next = 3'd4;
        end
        else if (c2_doe_reg >= DOE_W'(3 * CENT_DAYS))
        begin
            cent_next = 3'd3;
        end
        else if (c2_doe_reg >= DOE_W'(2 * CENT_DAYS))
        begin
            cent_next = 3'd2;
        end
        else if (c2_doe_reg >= DOE_W'(CENT_DAYS))
        begin
            cent_next = 3'd1;
        end
        else
        begin
            cent_next = 3'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            c3_era_reg  <= c2_era_reg;
            c3_doe_reg  <= c2_doe_reg;
            c3_quad_reg <= qprod[QUAD_SH+6:QUAD_SH];
            c3_cent_reg <= cent_next;
            c3_last_reg <= c2_doe_reg == DOE_W'(ERA_DAYS - 1);
            c3_side_reg <= c2_side_reg;
        end
    end

    logic [DOE_W-1:0]  n_next;
    logic [DIV_PW-1:0] yprod;
    logic [4:0]        c4_era_reg;
    logic [DOE_W-1:0]  c4_doe_reg;
    logic [8:0]        c4_yoe_reg;
    res_side_t         c4_side_reg;

    // Stage four: year of era from the corrected day count.
    always_comb
    begin
        n_next = c3_doe_reg - DOE_W'(c3_quad_reg) + DOE_W'(c3_cent_reg)
               - DOE_W'(c3_last_reg);
        yprod  = DIV_PW'(n_next) * DIV_PW'(DIV_MUL);
    end

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            c4_era_reg  <= c3_era_reg;
            c4_doe_reg  <= c3_doe_reg;
            c4_yoe_reg  <= yprod[YEAR_SH+8:YEAR_SH];
            c4_side_reg <= c3_side_reg;
        end
    end

    logic [DOE_W-1:0] ystart;
    logic [DOE_W-1:0] doy_wide;
    logic [4:0]       c5_era_reg;
    logic [8:0]       c5_yoe_reg;
    logic [8:0]       c5_doy_reg;
    res_side_t        c5_side_reg;

    // Stage five: day within the March-based year.
    always_comb
    begin
        ystart   = DOE_W'(c4_yoe_reg) * DOE_W'(YEAR_DAYS) + DOE_W'(c4_yoe_reg[8:2])
                 - DOE_W'(cent_of(c4_yoe_reg));
        doy_wide = c4_doe_reg - ystart;
    end

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            c5_era_reg  <= c4_era_reg;
            c5_yoe_reg  <= c4_yoe_reg;
            c5_doy_reg  <= doy_wide[8:0];
            c5_side_reg <= c4_side_reg;
        end
    end

    logic [10:0]      mp_arg;
    logic [MP_PW-1:0] mprod;
    logic [4:0]       c6_era_reg;
    logic [8:0]       c6_yoe_reg;
    logic [8:0]       c6_doy_reg;
    logic [3:0]       c6_mp_reg;
    res_side_t        c6_side_reg;

    // Stage six: month index counted from March.
    always_comb
    begin
        mp_arg = 11'(c5_doy_reg) * 11'd5 + 11'd2;
        mprod  = MP_PW'(mp_arg) * MP_PW'(MP_MUL);
    end

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            c6_era_reg  <= c5_era_reg;
            c6_yoe_reg  <= c5_yoe_reg;
            c6_doy_reg  <= c5_doy_reg;
            c6_mp_reg   <= mprod[MP_SH+3:MP_SH];
            c6_side_reg <= c5_side_reg;
        end
    end

    logic [8:0]  dom_wide;
    month_t      mon_next;
    year_t       yr_next;
    logic        date_op;
    count_t      num_reg;
    year_t       yr_reg;
    month_t      mon_reg;
    mday_t       dom_reg;
    logic        flag_reg;

    // Stage seven: calendar fields, and fields an operation does not use read as zero.
    always_comb
    begin
        dom_wide = c6_doy_reg - cum_days(c6_mp_reg) + 9'd1;
        mon_next = (c6_mp_reg < 4'd10) ? c6_mp_reg + 4'd3 : c6_mp_reg - 4'd9;
        yr_next  = YEAR_W'(c6_yoe_reg) + YEAR_W'(c6_era_reg) * YEAR_W'(ERA_YEARS)
                 + YEAR_W'(mon_next <= 4'd2);
        date_op  = (c6_side_reg.op == OP_TO_DATE) || (c6_side_reg.op == OP_ADD_DAYS);
    end

    always_ff @(posedge clk)
    begin
        if (adv[6])
        begin
            if (date_op)
            begin
                num_reg  <= '0;
                yr_reg   <= yr_next;
                mon_reg  <= mon_next;
                dom_reg  <= dom_wide[DAY_W-1:0];
                flag_reg <= c6_side_reg.flag;
            end
            else
            begin
                num_reg  <= c6_side_reg.num;
                yr_reg   <= '0;
                mon_reg  <= '0;
                dom_reg  <= '0;
                flag_reg <= 1'b0;
            end
        end
    end

    assign day_number   = num_reg;
    assign out_year     = yr_reg;
    assign out_month    = mon_reg;
    assign out_day      = dom_reg;
    assign out_of_range = flag_reg;

endmodule

`default_nettype wire

// File: test/date_conversion_checker.sv
`timescale 1ns / 100ps
// Checker that predicts each converter response and compares it field by field.
module date_conversion_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    input  logic             req_stall,
    input  cdsd_pkg::op_t    op,
    input  cdsd_pkg::year_t  year,
    input  cdsd_pkg::month_t month,
    input  cdsd_pkg::mday_t  day,
    input  cdsd_pkg::year_t  year_b,
    input  cdsd_pkg::month_t month_b,
    input  cdsd_pkg::mday_t  day_b,
    input  cdsd_pkg::count_t day_count,
    input  logic             rsp_valid,
    input  logic             rsp_stall,
    input  cdsd_pkg::count_t day_number,
    input  cdsd_pkg::year_t  out_year,
    input  cdsd_pkg::month_t out_month,
    input  cdsd_pkg::mday_t  out_day,
    input  logic             out_of_range,
    output int               mismatches,
    output int               outstanding
);
    import cdsd_pkg::*;

    // Calendar figures of the March-based year, counted from 1970-01-01.
    localparam longint EPOCH_OFFSET = 719468;
    localparam longint DAYS_PER_ERA = 146097;
    localparam longint FIRST_SERIAL = -719162;
    localparam longint LAST_SERIAL  = 2932896;
    localparam longint COUNT_LIMIT  = 3652058;

    typedef struct {
        count_t day_number;
        year_t  year;
        month_t month;
        mday_t  day;
        logic   clamped;
    } conversion_t;

    conversion_t expected_conversions[$];

    // Serial day of a date; any field value is accepted, valid or not.
    function automatic longint serial_of_date(input year_t yr, input month_t mo,
                                              input mday_t dy);
        longint y, m, d, era, yoe, doy, doe;
        y = yr;
        m = mo;
        d = dy;
        // January and February belong to the previous March-based year.
        if (m <= 2)
            y = y - 1;
        era = (y + 400) / 400 - 1;
        yoe = y - era * 400;
        doy = (153 * ((m > 2) ? m - 3 : m + 9) + 2) / 5 + d - 1;
        doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        return era * DAYS_PER_ERA + doe - EPOCH_OFFSET;
    endfunction

    // Date of a serial day, clamped to years 1 to 9999 and flagged when clamped.
    function automatic conversion_t date_of_serial(input longint serial);
        conversion_t res;
        longint s, z, era, doe, yoe, doy, mp, mm, yy, dd;
        res = '{default: '0};
        s = serial;
        if (s < FIRST_SERIAL) begin
            s = FIRST_SERIAL;
            res.clamped = 1'b1;
        end else if (s > LAST_SERIAL) begin
            s = LAST_SERIAL;
            res.clamped = 1'b1;
        end
        z   = s + EPOCH_OFFSET;
        era = z / DAYS_PER_ERA;
        doe = z - era * DAYS_PER_ERA;
        // Leap-day corrections per four years, century and era.
        yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
        doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
        mp  = (5 * doy + 2) / 153;
        dd  = doy - (153 * mp + 2) / 5 + 1;
        mm  = (mp < 10) ? mp + 3 : mp - 9;
        yy  = yoe + era * 400 + ((mm <= 2) ? 1 : 0);
        res.year  = year_t'(yy);
        res.month = month_t'(mm);
        res.day   = mday_t'(dd);
        return res;
    endfunction

    function automatic longint saturate_count(input longint v);
        if (v > COUNT_LIMIT)
            return COUNT_LIMIT;
        if (v < -COUNT_LIMIT)
            return -COUNT_LIMIT;
        return v;
    endfunction

    // Expected response of one request.
    function automatic conversion_t convert_request(input op_t kind,
                                                    input year_t ya, input month_t ma,
                                                    input mday_t da, input year_t yb,
                                                    input month_t mb, input mday_t db,
                                                    input count_t offset);
        conversion_t res;
        longint first;
        res = '{default: '0};
        first = serial_of_date(ya, ma, da);
        case (kind)
            OP_TO_DAYS:
                res.day_number = count_t'(saturate_count(first));
            OP_TO_DATE:
                res = date_of_serial(offset);
            OP_ADD_DAYS:
                res = date_of_serial(first + offset);
            OP_DAYS_BETWEEN:
                res.day_number = count_t'(saturate_count(serial_of_date(yb, mb, db) - first));
            default:
                res = '{default: '0};
        endcase
        return res;
    endfunction

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
    end

    // Record each accepted request and compare each accepted response with the oldest one.
    always @(posedge clk)
    begin
        conversion_t want;
        if (rst_n) begin
            if (req_valid && !req_stall)
                expected_conversions.push_back(convert_request(op, year, month, day, year_b,
                                                               month_b, day_b, day_count));
            if (rsp_valid && !rsp_stall) begin
                if (expected_conversions.size() == 0) begin
                    $error("response with no request outstanding");
                    mismatches++;
                end else begin
                    want = expected_conversions.pop_front();
                    if (day_number !== want.day_number) begin
                        $error("day_number: expected %0d, got %0d", want.day_number, day_number);
                        mismatches++;
                    end
                    if (out_year !== want.year) begin
                        $error("out_year: expected %0d, got %0d", want.year, out_year);
                        mismatches++;
                    end
                    if (out_month !== want.month) begin
                        $error("out_month: expected %0d, got %0d", want.month, out_month);
                        mismatches++;
                    end
                    if (out_day !== want.day) begin
                        $error("out_day: expected %0d, got %0d", want.day, out_day);
                        mismatches++;
                    end
                    if (out_of_range !== want.clamped) begin
                        $error("out_of_range: expected %0b, got %0b", want.clamped,
                               out_of_range);
                        mismatches++;
                    end
                end
            end
            outstanding = expected_conversions.size();
        end
    end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps
// Testbench top of the civil date converter: stimulus, response stalls and verdict.
module tb_top;
    import cdsd_pkg::*;

    localparam int RANDOM_REQUESTS = 1250;
    localparam int IDLE_LIMIT      = 4000;

    logic   clk          = 1'b0;
    logic   rst_n        = 1'b0;
    logic   req_valid    = 1'b0;
    logic   req_stall;
    op_t    op           = OP_TO_DAYS;
    year_t  year         = '0;
    month_t month        = '0;
    mday_t  day          = '0;
    year_t  year_b       = '0;
    month_t month_b      = '0;
    mday_t  day_b        = '0;
    count_t day_count    = '0;
    logic   rsp_valid;
    logic   rsp_stall    = 1'b0;
    count_t day_number;
    year_t  out_year;
    month_t out_month;
    mday_t  out_day;
    logic   out_of_range;

    int mismatches;
    int outstanding;

    int burst_left  = 0;
    bit drain_next  = 1'b0;
    int idle_cycles = 0;
    int stall_mode  = 0;
    int stall_left  = 0;
    int stall_tick  = 0;

    civil_date_serial_day_converter_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .op           (op),
        .year         (year),
        .month        (month),
        .day          (day),
        .year_b       (year_b),
        .month_b      (month_b),
        .day_b        (day_b),
        .day_count    (day_count),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .day_number   (day_number),
        .out_year     (out_year),
        .out_month    (out_month),
        .out_day      (out_day),
        .out_of_range (out_of_range)
    );

    date_conversion_checker conv_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .op           (op),
        .year         (year),
        .month        (month),
        .day          (day),
        .year_b       (year_b),
        .month_b      (month_b),
        .day_b        (day_b),
        .day_count    (day_count),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .day_number   (day_number),
        .out_year     (out_year),
        .out_month    (out_month),
        .out_day      (out_day),
        .out_of_range (out_of_range),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    // 12 ns clock.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Response stalls: phases of no stall, even stall, heavy stall and a fixed pattern.
    always @(posedge clk)
    begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 300);
        end else begin
            stall_left <= stall_left - 1;
        end
        stall_tick <= stall_tick + 1;
        case (stall_mode)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= $urandom_range(0, 1);
            2:       rsp_stall <= ($urandom_range(0, 7) != 0);
            default: rsp_stall <= (stall_tick % 5 < 3);
        endcase
    end

    // Watchdog on cycles in which neither channel moves anything.
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Present one request, hold it until taken, then either carry on the burst or pause.
    task automatic send_request(input op_t kind, input year_t ya, input month_t ma,
                                input mday_t da, input year_t yb, input month_t mb,
                                input mday_t db, input count_t offset);
        req_valid <= 1'b1;
        op        <= kind;
        year      <= ya;
        month     <= ma;
        day       <= da;
        year_b    <= yb;
        month_b   <= mb;
        day_b     <= db;
        day_count <= offset;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        if (burst_left > 0 && !drain_next) begin
            burst_left--;
        end else begin
            req_valid <= 1'b0;
            if (drain_next) begin
                // Hold off until every outstanding response has been returned.
                do
                    @(negedge clk);
                while (outstanding != 0);
                @(posedge clk);
                drain_next = 1'b0;
            end else begin
                repeat ($urandom_range(1, 12))
                    @(posedge clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(0, 20);
        end
    endtask

    // Mostly ordinary dates, some at the ends of the year span, a few with any field bits.
    function automatic void pick_date(output year_t y, output month_t m, output mday_t d);
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 75) begin
            y = $urandom_range(1, 9999);
            m = $urandom_range(1, 12);
            d = $urandom_range(0, 1) ? $urandom_range(1, 28) : $urandom_range(1, 31);
        end else if (sel < 90) begin
            y = $urandom_range(0, 1) ? $urandom_range(1, 3) : $urandom_range(9997, 9999);
            m = $urandom_range(1, 12);
            d = $urandom_range(1, 31);
        end else begin
            y = $urandom;
            m = $urandom;
            d = $urandom;
        end
    endfunction

    // Day counts: short offsets, the valid span, near the clamp limits, the saturation span and any bit pattern.
    function automatic count_t pick_count();
        longint v;
        case ($urandom_range(0, 4))
            0:       v = longint'($urandom_range(0, 4000)) - 2000;
            1:       v = longint'($urandom_range(0, 3652058)) - 719162;
            2:       v = ($urandom_range(0, 1) ? -719162 : 2932896)
                         + longint'($urandom_range(0, 8)) - 4;
            3:       v = longint'($urandom_range(0, 7304116)) - 3652058;
            default: v = $urandom;
        endcase
        return count_t'(v);
    endfunction

    initial
    begin
        year_t  ya, yb;
        month_t ma, mb;
        mday_t  da, db;

        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;

        // Directed requests: span limits, clamping on both sides, saturation, odd fields.
        send_request(OP_TO_DAYS, 1970, 1, 1, 0, 0, 0, 0);
        send_request(OP_TO_DAYS, 1, 1, 1, 9999, 12, 31, -1);
        send_request(OP_TO_DAYS, 9999, 12, 31, 1, 1, 1, 23'h3FFFFF);
        send_request(OP_TO_DAYS, 2000, 2, 29, 0, 0, 0, 0);
        send_request(OP_TO_DAYS, 0, 0, 0, 0, 0, 0, 0);
        send_request(OP_TO_DAYS, 16383, 15, 31, 16383, 15, 31, -4194304);
        send_request(OP_TO_DAYS, 2023, 13, 0, 0, 0, 0, 0);
        send_request(OP_TO_DATE, 0, 0, 0, 0, 0, 0, 0);
        send_request(OP_TO_DATE, 16383, 15, 31, 16383, 15, 31, -719162);
        send_request(OP_TO_DATE, 0, 0, 0, 0, 0, 0, -719163);
        send_request(OP_TO_DATE, 0, 0, 0, 0, 0, 0, 2932896);
        send_request(OP_TO_DATE, 0, 0, 0, 0, 0, 0, 2932897);
        send_request(OP_TO_DATE, 0, 0, 0, 0, 0, 0, 23'h3FFFFF);
        send_request(OP_TO_DATE, 0, 0, 0, 0, 0, 0, -4194304);
        send_request(OP_TO_DATE, 0, 0, 0, 0, 0, 0, 11016);
        send_request(OP_ADD_DAYS, 2024, 2, 28, 0, 0, 0, 1);
        send_request(OP_ADD_DAYS, 9999, 12, 31, 0, 0, 0, 1);
        send_request(OP_ADD_DAYS, 1, 1, 1, 0, 0, 0, -1);
        send_request(OP_ADD_DAYS, 1, 1, 1, 0, 0, 0, 3652058);
        send_request(OP_ADD_DAYS, 16383, 15, 31, 0, 0, 0, -4194304);
        send_request(OP_DAYS_BETWEEN, 1, 1, 1, 9999, 12, 31, 0);
        send_request(OP_DAYS_BETWEEN, 9999, 12, 31, 1, 1, 1, 23'h3FFFFF);
        send_request(OP_DAYS_BETWEEN, 0, 0, 0, 16383, 15, 31, 0);
        send_request(OP_DAYS_BETWEEN, 16383, 15, 31, 0, 0, 0, 0);
        drain_next = 1'b1;
        send_request(OP_DAYS_BETWEEN, 2000, 3, 1, 2000, 2, 28, 0);

        // Random requests, with the odd pause until the pipeline has emptied.
        for (int i = 0; i < RANDOM_REQUESTS; i++) begin
            pick_date(ya, ma, da);
            pick_date(yb, mb, db);
            if (i == RANDOM_REQUESTS - 1 || $urandom_range(0, 299) == 0)
                drain_next = 1'b1;
            send_request(op_t'($urandom_range(0, 3)), ya, ma, da, yb, mb, db, pick_count());
        end

        // Allow any stray response to show itself before the verdict.
        repeat (40)
            @(negedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: files.f
rtl/core/cdsd_pkg.sv
rtl/core/cdsd_serial.sv
rtl/core/cdsd_civil.sv
rtl/core/civil_date_serial_day_converter_top.sv
test/date_conversion_checker.sv
test/tb_top.sv
